/* hdl/assert_macros.svh */
// Assertion macros shared by the permission table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define RPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that is also checked during reset.
`define RPT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

/* hdl/rpt_pkg.sv */
// Shared widths, defaults and types of the role permission table.
`timescale 1ns / 1ps

package rpt_pkg;

  localparam int WORD_W   = 64;
  localparam int LOW_W    = 32;
  localparam int ROLE_W   = 4 * WORD_W;
  localparam int MEMBER_W = 2 * WORD_W + LOW_W;
  localparam int KEY_W    = ROLE_W + MEMBER_W;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam int TABLE_DEPTH_DEF = 256;

  // Registered outcome of one compare in the table scan.
  typedef struct packed {
    logic valid;
    logic hit;
  } scan_res_t;

endpackage

/* hdl/rpt_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module rpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/rpt_cmp.sv */
// Shared key compare unit: matches one stored pair against the request per cycle.
`timescale 1ns / 1ps

module rpt_cmp #(
  parameter int IDX_W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [IDX_W-1:0]         in_idx,
  input  logic [rpt_pkg::KEY_W-1:0] key,
  input  logic [rpt_pkg::KEY_W-1:0] entry,
  output rpt_pkg::scan_res_t       res,
  output logic [IDX_W-1:0]         res_idx
);

  import rpt_pkg::*;

  logic             valid_r;
  logic             hit_r;
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  // The tag and the compare result need no reset; valid_r qualifies them.
  always_ff @(posedge clk) begin
    hit_r <= (key == entry);
    idx_r <= in_idx;
  end

  assign res.valid = valid_r;
  assign res.hit   = hit_r;
  assign res_idx   = idx_r;

endmodule

/* hdl/role_permission_table.sv */
// Top level of the role permission table: request sequencer, tables and admin registers.
// A grant or revoke by a non-admin caller, or the unused code, answers from the check state
// without a scan; any other request answers once its scan of the N stored pairs has ended.
// Throughput: one request at a time, busy until its result strobe; one pair per cycle.
// Reset (synchronous, active low) empties the table and sets the admin address to all ones.
// Results cannot be stalled by the receiver; no clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module role_permission_table #(
  parameter int TABLE_DEPTH = rpt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Request channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [rpt_pkg::FUNC_W-1:0]    in_func,
  input  logic [rpt_pkg::WORD_W-1:0]    in_role_word_0,
  input  logic [rpt_pkg::WORD_W-1:0]    in_role_word_1,
  input  logic [rpt_pkg::WORD_W-1:0]    in_role_word_2,
  input  logic [rpt_pkg::WORD_W-1:0]    in_role_word_3,
  input  logic [rpt_pkg::WORD_W-1:0]    in_member_high,
  input  logic [rpt_pkg::WORD_W-1:0]    in_member_middle,
  input  logic [rpt_pkg::LOW_W-1:0]     in_member_low,
  input  logic [rpt_pkg::WORD_W-1:0]    in_caller_high,
  input  logic [rpt_pkg::WORD_W-1:0]    in_caller_middle,
  input  logic [rpt_pkg::LOW_W-1:0]     in_caller_low,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpt_pkg::WORD_W-1:0]    cfg_data,
  // Result channel.
  output logic                          out_valid,
  output logic                          out_status,
  output logic                          out_holds_role
);

  import rpt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Function codes of a request.
  localparam logic [FUNC_W-1:0] FUNC_GRANT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REVOKE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ADMIN_HIGH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADMIN_MIDDLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ADMIN_LOW    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_ACT,
    ST_FLAG
  } state_t;

  // Sequencer state and registered outputs.
  state_t           state_r,      state_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic [CNT_W-1:0] issue_r,      issue_nxt;
  logic             rd_pend_r,    rd_pend_nxt;
  logic [IDX_W-1:0] rd_idx_r,     rd_idx_nxt;
  logic             found_r,      found_nxt;
  logic [IDX_W-1:0] hit_idx_r,    hit_idx_nxt;
  logic             out_valid_r,  out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic             out_holds_r,  out_holds_nxt;

  // Latched request.
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic              admin_ok_r;

  // Admin address registers.
  logic [WORD_W-1:0] admin_high_r;
  logic [WORD_W-1:0] admin_middle_r;
  logic [LOW_W-1:0]  admin_low_r;

  // Table and compare unit connections.
  scan_res_t        res;
  logic [IDX_W-1:0] res_idx;
  logic [KEY_W-1:0] entry_rdata;
  logic             flag_rdata;
  logic             accept;
  logic             scan_issue;
  logic             scan_hit;
  logic             scan_miss;
  logic             table_full;
  logic             append;
  logic             entry_we;
  logic             flag_we;
  logic [IDX_W-1:0] flag_waddr;
  logic             flag_wdata;
  logic             flag_re;
  logic             caller_is_admin;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign caller_is_admin = ({in_caller_high, in_caller_middle, in_caller_low} ==
                            {admin_high_r, admin_middle_r, admin_low_r});

  // The scan streams one table read per cycle; its compare result passes the RAM read register
  // and the compare register. It stops issuing on a hit and ends on a miss once the pipeline has drained.
  assign scan_issue = (state_r == ST_SCAN) && (issue_r != count_r) &&
                      !(res.valid && res.hit);
  assign scan_hit   = (state_r == ST_SCAN) && res.valid && res.hit;
  assign scan_miss  = (state_r == ST_SCAN) && (issue_r == count_r) && !rd_pend_r &&
                      !res.valid;

  assign table_full = (count_r == CNT_W'(TABLE_DEPTH));

  // A grant of an absent pair appends it at the end of the table, flag set, unless the table is full.
  assign append     = (state_r == ST_ACT) && (func_r == FUNC_GRANT) && !found_r &&
                      !table_full;
  assign entry_we   = append;
  assign flag_we    = append || ((state_r == ST_ACT) && found_r &&
                      ((func_r == FUNC_GRANT) || (func_r == FUNC_REVOKE)));
  assign flag_waddr = append ? count_r[IDX_W-1:0] : hit_idx_r;
  assign flag_wdata = (func_r == FUNC_GRANT);
  assign flag_re    = (state_r == ST_ACT) && (func_r == FUNC_QUERY) && found_r;

  rpt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (key_r),
    .re    (scan_issue),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (entry_rdata)
  );

  rpt_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (flag_re),
    .raddr (hit_idx_r),
    .rdata (flag_rdata)
  );

  rpt_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_pend_r),
    .in_idx   (rd_idx_r),
    .key      (key_r),
    .entry    (entry_rdata),
    .res      (res),
    .res_idx  (res_idx)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    rd_pend_nxt    = scan_issue;
    rd_idx_nxt     = issue_r[IDX_W-1:0];
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_holds_nxt  = out_holds_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        issue_nxt = '0;
        if ((func_r == FUNC_GRANT) || (func_r == FUNC_REVOKE)) begin
          if (admin_ok_r) begin
            state_nxt = ST_SCAN;
          end else begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b1;
            out_holds_nxt  = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end else if (func_r == FUNC_QUERY) begin
          state_nxt = ST_SCAN;
        end else begin
          // The unused function code changes nothing and reports success.
          out_valid_nxt  = 1'b1;
          out_status_nxt = 1'b0;
          out_holds_nxt  = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SCAN: begin
        issue_nxt = scan_issue ? (issue_r + CNT_W'(1)) : issue_r;
        if (scan_hit) begin
          found_nxt   = 1'b1;
          hit_idx_nxt = res_idx;
          state_nxt   = ST_ACT;
        end else if (scan_miss) begin
          found_nxt = 1'b0;
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        case (func_r)
          FUNC_GRANT: begin
            // A full table only refuses pairs it does not already hold.
            out_valid_nxt  = 1'b1;
            out_status_nxt = !found_r && table_full;
            out_holds_nxt  = 1'b0;
            count_nxt      = append ? (count_r + CNT_W'(1)) : count_r;
            state_nxt      = ST_IDLE;
          end
          FUNC_REVOKE: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            out_holds_nxt  = 1'b0;
            state_nxt      = ST_IDLE;
          end
          FUNC_QUERY: begin
            if (found_r) begin
              state_nxt = ST_FLAG;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = 1'b0;
              out_holds_nxt  = 1'b0;
              state_nxt      = ST_IDLE;
            end
          end
          default: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = 1'b0;
            out_holds_nxt  = 1'b0;
            state_nxt      = ST_IDLE;
          end
        endcase
      end
      ST_FLAG: begin
        // The granted flag of the matching pair has just been read.
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        out_holds_nxt  = flag_rdata;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer state and registered result outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      issue_r      <= '0;
      rd_pend_r    <= 1'b0;
      rd_idx_r     <= '0;
      found_r      <= 1'b0;
      hit_idx_r    <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= 1'b0;
      out_holds_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      issue_r      <= issue_nxt;
      rd_pend_r    <= rd_pend_nxt;
      rd_idx_r     <= rd_idx_nxt;
      found_r      <= found_nxt;
      hit_idx_r    <= hit_idx_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
      out_holds_r  <= out_holds_nxt;
    end
  end

  // The request is captured on its start transfer, and the admin check is made right there;
  // the admin address is to change only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      key_r      <= {in_role_word_0, in_role_word_1, in_role_word_2, in_role_word_3,
                     in_member_high, in_member_middle, in_member_low};
      admin_ok_r <= caller_is_admin;
    end
  end

  // Admin address registers, written through the configuration channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      admin_high_r   <= '1;
      admin_middle_r <= '1;
      admin_low_r    <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADMIN_HIGH:   admin_high_r   <= cfg_data;
        REG_ADMIN_MIDDLE: admin_middle_r <= cfg_data;
        REG_ADMIN_LOW:    admin_low_r    <= cfg_data[LOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_holds_role = out_holds_r;

  // A start transfer always makes the block busy in the following cycle.
  `RPT_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "start transfer not followed by busy")
  // A result strobe only ever closes a request in progress.
  `RPT_ASSERT(a_result_after_work, out_valid |-> $past(state_r != ST_IDLE), "result without request")
  // The pair count never passes the table depth.
  `RPT_ASSERT(a_count_bound, count_r <= CNT_W'(TABLE_DEPTH), "pair count beyond table depth")
  // The pair count only ever grows by one pair at a time.
  `RPT_ASSERT(a_count_step, ($past(rst_n) && (count_r != $past(count_r))) |-> (count_r == $past(count_r) + CNT_W'(1)), "pair count jumped")
  // A query never reports a failure status.
  `RPT_ASSERT(a_query_status, (out_valid && (func_r == FUNC_QUERY)) |-> !out_status, "query reported failure")

endmodule
